// ===== rtl/cmb_pkg.sv =====
// Shared types and constants for the 3x3 mirror-border convolution unit.
// No dependencies.
`default_nettype none
package cmb_pkg;

    localparam int ROW_BITS  = 12;
    localparam int OCOL_BITS = 10;
    localparam int FILT_BITS = 28;
    localparam int FW_BITS   = 11;
    localparam int FH_BITS   = 13;
    localparam int ADDR_BITS = 3;
    localparam int OUT_DW    = ((ROW_BITS + OCOL_BITS + FILT_BITS + 7) / 8) * 8;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_KTOP    = 3'd0,
        REG_KMID    = 3'd1,
        REG_KBOT    = 3'd2,
        REG_FWIDTH  = 3'd3,
        REG_FHEIGHT = 3'd4
    } cfg_reg_e;

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic                last_row;
        logic                row_end;
    } item_ctl_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [OCOL_BITS-1:0] col;
        logic                 run_last;
        logic                 frame_done;
    } res_tag_t;

endpackage
`default_nettype wire

// ===== rtl/cmb_line_buf.sv =====
// Raster position counters and the two line memories (read, then write back).
// Depends on cmb_pkg.
`default_nettype none
module cmb_line_buf #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [cmb_pkg::FW_BITS-1:0] frame_width,
    input  wire logic [cmb_pkg::FH_BITS-1:0] frame_height,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [PIXEL_BITS-1:0]       in_pixel,
    output logic                             o_valid,
    input  wire logic                        o_ready,
    output logic [PIXEL_BITS-1:0]            o_pixel,
    output logic [PIXEL_BITS-1:0]            o_top,
    output logic [PIXEL_BITS-1:0]            o_mid,
    output logic [CW-1:0]                    o_col,
    output cmb_pkg::item_ctl_t               o_ctl
);
    import cmb_pkg::*;

    localparam int WW = (CW + 1 > FW_BITS) ? CW + 1 : FW_BITS;

    logic [PIXEL_BITS-1:0] line_above [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] line_two_above [MAX_WIDTH];

    logic [CW-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [WW-1:0]       w_eff;
    logic [FH_BITS-1:0]  h_eff;
    logic                last_row, row_end, in_acc, leave;

    logic                  v1_reg;
    logic [PIXEL_BITS-1:0] pix1_reg, top_reg, mid_reg;
    logic [CW-1:0]         col1_reg;
    item_ctl_t             ctl1_reg;

    always_comb begin
        w_eff = WW'(frame_width);
        if (w_eff < WW'(2)) begin
            w_eff = WW'(2);
        end else if (w_eff > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end
        h_eff = frame_height;
        if (h_eff < FH_BITS'(2)) begin
            h_eff = FH_BITS'(2);
        end else if (h_eff > FH_BITS'(4096)) begin
            h_eff = FH_BITS'(4096);
        end
    end

    assign last_row = {1'b0, row_reg} >= (h_eff - FH_BITS'(1));
    assign row_end  = WW'(col_reg) >= (w_eff - WW'(1));
    assign leave    = v1_reg && o_ready;
    assign in_ready = !v1_reg || o_ready;
    assign in_acc   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            if (in_acc) begin
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_BITS'(1);
                end else begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (in_acc) begin
                v1_reg <= 1'b1;
            end else if (leave) begin
                v1_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pix1_reg <= in_pixel;
            col1_reg <= col_reg;
            ctl1_reg <= '{row: row_reg, last_row: last_row, row_end: row_end};
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            mid_reg <= line_above[col_reg];
        end
        if (leave) begin
            line_above[col1_reg] <= pix1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            top_reg <= line_two_above[col_reg];
        end
        if (leave) begin
            line_two_above[col1_reg] <= mid_reg;
        end
    end

    assign o_valid = v1_reg;
    assign o_pixel = pix1_reg;
    assign o_top   = top_reg;
    assign o_mid   = mid_reg;
    assign o_col   = col1_reg;
    assign o_ctl   = ctl1_reg;

endmodule
`default_nettype wire

// ===== rtl/cmb_window.sv =====
// 3x3 window registers and the per-item result sequencer with mirror selection.
// Depends on cmb_pkg.
`default_nettype none
module cmb_window #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [PIXEL_BITS-1:0]            in_pixel,
    input  wire logic [PIXEL_BITS-1:0]            in_top,
    input  wire logic [PIXEL_BITS-1:0]            in_mid,
    input  wire logic [CW-1:0]                    in_col,
    input  wire cmb_pkg::item_ctl_t               in_ctl,
    output logic                                  o_valid,
    input  wire logic                             o_ready,
    output logic [2:0][PIXEL_BITS-1:0]            o_top,
    output logic [2:0][PIXEL_BITS-1:0]            o_mid,
    output logic [2:0][PIXEL_BITS-1:0]            o_bot,
    output cmb_pkg::res_tag_t                     o_tag
);
    import cmb_pkg::*;

    // win_reg[column oldest..newest][top, mid, bot]
    logic [2:0][2:0][PIXEL_BITS-1:0] win_reg;
    logic [3:0]          mask_reg, low_bit, mask_new;
    logic [CW-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic                last_row_reg, row_end_reg;
    logic                single, upper, main_pos, first, in_acc, taken;
    logic                en_main, en_end;
    logic [2:0][PIXEL_BITS-1:0] vec [3];

    assign low_bit  = mask_reg & (~mask_reg + 4'd1);
    assign single   = (mask_reg & (mask_reg - 4'd1)) == 4'd0;
    assign o_valid  = mask_reg != 4'd0;
    assign taken    = o_valid && o_ready;
    assign in_ready = !o_valid || (single && o_ready);
    assign in_acc   = in_valid && in_ready;

    assign en_main  = (in_ctl.row != '0) && (in_col != '0);
    assign en_end   = (in_ctl.row != '0) && in_ctl.row_end;
    assign mask_new = {en_end && in_ctl.last_row, en_end,
                       en_main && in_ctl.last_row, en_main};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= '0;
            mask_reg <= '0;
        end else begin
            if (in_acc) begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= {in_pixel, in_mid, in_top};
                mask_reg   <= mask_new;
            end else if (taken) begin
                mask_reg <= mask_reg & ~low_bit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            col_reg      <= in_col;
            row_reg      <= in_ctl.row;
            last_row_reg <= in_ctl.last_row;
            row_end_reg  <= in_ctl.row_end;
        end
    end

    assign upper    = low_bit[0] || low_bit[2];
    assign main_pos = low_bit[0] || low_bit[1];
    assign first    = col_reg == CW'(1);

    always_comb begin
        vec[0] = main_pos ? (first ? win_reg[2] : win_reg[0]) : win_reg[1];
        vec[1] = main_pos ? win_reg[1] : win_reg[2];
        vec[2] = main_pos ? win_reg[2] : win_reg[1];
        for (int j = 0; j < 3; j++) begin
            if (upper) begin
                o_top[j] = (row_reg == ROW_BITS'(1)) ? vec[j][2] : vec[j][0];
                o_mid[j] = vec[j][1];
                o_bot[j] = vec[j][2];
            end else begin
                o_top[j] = vec[j][1];
                o_mid[j] = vec[j][2];
                o_bot[j] = vec[j][1];
            end
        end
        o_tag.row        = upper ? row_reg - ROW_BITS'(1) : row_reg;
        o_tag.col        = OCOL_BITS'(main_pos ? col_reg - CW'(1) : col_reg);
        o_tag.run_last   = single;
        o_tag.frame_done = single && last_row_reg && row_end_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/cmb_mac.sv =====
// Two-stage multiply and sum of the 3x3 window against the kernel, output register.
// Depends on cmb_pkg.
`default_nettype none
module cmb_mac #(
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [3*COEF_BITS-1:0]          kernel_top,
    input  wire logic [3*COEF_BITS-1:0]          kernel_mid,
    input  wire logic [3*COEF_BITS-1:0]          kernel_bot,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [2:0][PIXEL_BITS-1:0]      in_top,
    input  wire logic [2:0][PIXEL_BITS-1:0]      in_mid,
    input  wire logic [2:0][PIXEL_BITS-1:0]      in_bot,
    input  wire cmb_pkg::res_tag_t               in_tag,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cmb_pkg::OUT_DW-1:0]           m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);
    import cmb_pkg::*;

    localparam int PW = PIXEL_BITS + 1 + COEF_BITS;

    logic signed [PW-1:0] prod_reg [9];
    logic                 v1_reg, out_ready;
    res_tag_t             tag1_reg, tag_out_reg;
    logic signed [FILT_BITS-1:0] sum, sum_reg;

    assign out_ready = !m_tvalid || m_tready;
    assign in_ready  = !v1_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (in_ready) begin
                v1_reg <= in_valid;
            end
            if (out_ready) begin
                m_tvalid <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tag1_reg <= in_tag;
            for (int k = 0; k < 3; k++) begin
                prod_reg[k]   <= PW'($signed({1'b0, in_top[k]})
                                     * $signed(kernel_top[k*COEF_BITS +: COEF_BITS]));
                prod_reg[3+k] <= PW'($signed({1'b0, in_mid[k]})
                                     * $signed(kernel_mid[k*COEF_BITS +: COEF_BITS]));
                prod_reg[6+k] <= PW'($signed({1'b0, in_bot[k]})
                                     * $signed(kernel_bot[k*COEF_BITS +: COEF_BITS]));
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < 9; k++) begin
            sum = sum + FILT_BITS'(prod_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && v1_reg) begin
            sum_reg     <= sum;
            tag_out_reg <= tag1_reg;
        end
    end

    assign m_tdata = {(OUT_DW - ROW_BITS - OCOL_BITS - FILT_BITS)'(0), sum_reg,
                      tag_out_reg.col, tag_out_reg.row};
    assign m_tlast = tag_out_reg.run_last;
    assign m_tuser = tag_out_reg.frame_done;

endmodule
`default_nettype wire

// ===== rtl/conv3x3_mirror_border_unit.sv =====
// 3x3 convolution with mirror borders: config registers, line memories, window, MAC.
// One item per cycle in rows above the last, except at a row end, while the output
// is not stalled; the window sequencer issues one result per cycle when not stalled,
// so a last-row item gives two results and a row end two (last row four). Reset:
// synchronous, clears counters, window and pipeline valids; kernels 0, width 2,
// height 2. Line memories are not cleared.
// Depends on cmb_pkg, cmb_line_buf, cmb_window, cmb_mac.
`default_nettype none
module conv3x3_mirror_border_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 16,
    localparam int IN_DW = ((PIXEL_BITS + 7) / 8) * 8,
    localparam int CFG_W = (3 * COEF_BITS > 13) ? 3 * COEF_BITS : 13
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [cmb_pkg::ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]               cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [IN_DW-1:0]               s_tdata,   // pixel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [cmb_pkg::OUT_DW-1:0]          m_tdata,   // out_row, out_col, filtered
    output logic                                m_tlast,   // run_last
    output logic                                m_tuser    // frame_done
);
    import cmb_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [3*COEF_BITS-1:0] ktop_reg, kmid_reg, kbot_reg;
    logic [FW_BITS-1:0]     fwidth_reg;
    logic [FH_BITS-1:0]     fheight_reg;

    logic                  lb_valid, lb_ready, wn_valid, wn_ready;
    logic [PIXEL_BITS-1:0] lb_pixel, lb_top, lb_mid;
    logic [CW-1:0]         lb_col;
    item_ctl_t             lb_ctl;
    logic [2:0][PIXEL_BITS-1:0] wn_top, wn_mid, wn_bot;
    res_tag_t              wn_tag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ktop_reg    <= '0;
            kmid_reg    <= '0;
            kbot_reg    <= '0;
            fwidth_reg  <= FW_BITS'(2);
            fheight_reg <= FH_BITS'(2);
        end else if (cfg_we) begin
            case (cfg_reg_e'(cfg_addr))
                REG_KTOP:    ktop_reg    <= cfg_wdata[3*COEF_BITS-1:0];
                REG_KMID:    kmid_reg    <= cfg_wdata[3*COEF_BITS-1:0];
                REG_KBOT:    kbot_reg    <= cfg_wdata[3*COEF_BITS-1:0];
                REG_FWIDTH:  fwidth_reg  <= cfg_wdata[FW_BITS-1:0];
                REG_FHEIGHT: fheight_reg <= cfg_wdata[FH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    cmb_line_buf #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_line_buf (
        .aclk(aclk), .aresetn(aresetn),
        .frame_width(fwidth_reg), .frame_height(fheight_reg),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_pixel(s_tdata[PIXEL_BITS-1:0]),
        .o_valid(lb_valid), .o_ready(lb_ready), .o_pixel(lb_pixel),
        .o_top(lb_top), .o_mid(lb_mid), .o_col(lb_col), .o_ctl(lb_ctl)
    );

    cmb_window #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_window (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(lb_valid), .in_ready(lb_ready), .in_pixel(lb_pixel),
        .in_top(lb_top), .in_mid(lb_mid), .in_col(lb_col), .in_ctl(lb_ctl),
        .o_valid(wn_valid), .o_ready(wn_ready),
        .o_top(wn_top), .o_mid(wn_mid), .o_bot(wn_bot), .o_tag(wn_tag)
    );

    cmb_mac #(.PIXEL_BITS(PIXEL_BITS), .COEF_BITS(COEF_BITS)) u_mac (
        .aclk(aclk), .aresetn(aresetn),
        .kernel_top(ktop_reg), .kernel_mid(kmid_reg), .kernel_bot(kbot_reg),
        .in_valid(wn_valid), .in_ready(wn_ready),
        .in_top(wn_top), .in_mid(wn_mid), .in_bot(wn_bot), .in_tag(wn_tag),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for conv3x3_mirror_border_unit: streams frames of pixels,
// predicts every filtered result in-line and compares each output item.
// Depends on cmb_pkg and the unit's RTL.
`default_nettype none
module testbench;
    import cmb_pkg::*;

    localparam int MAXW = 1024;
    localparam int CFG_W = 48;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [OCOL_BITS-1:0] col;
        logic [FILT_BITS-1:0] filt;
        logic                 last;
        logic                 done;
    } conv_res_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [ADDR_BITS-1:0] cfg_addr = REG_KTOP;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_DW-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    conv3x3_mirror_border_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // predictor state
    logic [47:0] k_top, k_mid, k_bot;
    logic [10:0] fw_reg;
    logic [12:0] fh_reg;
    logic [7:0] lb1 [MAXW];
    logic [7:0] lb2 [MAXW];
    logic [7:0] win [3][3];
    int unsigned cur_row, cur_col;
    conv_res_t expected_q[$];
    int errors = 0;
    int n_items = 0, n_results = 0;
    longint cycles = 0;
    bit rx_hold_off = 0;

    function automatic longint coef(logic [47:0] r, int k);
        return longint'($signed(r[k*16 +: 16]));
    endfunction

    function automatic longint row_dot(logic [47:0] r, int a, int b, int c);
        return a * coef(r, 0) + b * coef(r, 1) + c * coef(r, 2);
    endfunction

    function automatic conv_res_t filter_at(int orow, int ocol, int c0, int c1, int c2,
                                            bit upper);
        conv_res_t r;
        int cs [3];
        int t [3], m [3], b [3];
        longint s;
        cs[0] = c0; cs[1] = c1; cs[2] = c2;
        for (int j = 0; j < 3; j++) begin
            if (upper) begin
                t[j] = (cur_row == 1) ? int'(win[cs[j]][2]) : int'(win[cs[j]][0]);
                m[j] = int'(win[cs[j]][1]);
                b[j] = int'(win[cs[j]][2]);
            end else begin
                t[j] = int'(win[cs[j]][1]);
                m[j] = int'(win[cs[j]][2]);
                b[j] = int'(win[cs[j]][1]);
            end
        end
        s = row_dot(k_top, t[0], t[1], t[2]) + row_dot(k_mid, m[0], m[1], m[2])
            + row_dot(k_bot, b[0], b[1], b[2]);
        r.row = ROW_BITS'(orow);
        r.col = OCOL_BITS'(ocol);
        r.filt = s[FILT_BITS-1:0];
        r.last = 0;
        r.done = 0;
        return r;
    endfunction

    task automatic predict_pixel(logic [7:0] p);
        int unsigned w, h, idx;
        bit last_row, row_end;
        conv_res_t res [$];
        w = 32'(fw_reg);
        if (w < 2) w = 2;
        if (w > MAXW) w = MAXW;
        h = 32'(fh_reg);
        if (h < 2) h = 2;
        if (h > 4096) h = 4096;
        idx = cur_col;
        for (int j = 0; j < 3; j++) begin
            win[0][j] = win[1][j];
            win[1][j] = win[2][j];
        end
        win[2][0] = lb2[idx];
        win[2][1] = lb1[idx];
        win[2][2] = p;
        lb2[idx] = lb1[idx];
        lb1[idx] = p;
        last_row = cur_row >= h - 1;
        row_end = cur_col >= w - 1;
        if (cur_row >= 1) begin
            if (cur_col >= 1) begin
                if (cur_col == 1) begin
                    res.push_back(filter_at(cur_row - 1, cur_col - 1, 2, 1, 2, 1));
                    if (last_row) res.push_back(filter_at(cur_row, cur_col - 1, 2, 1, 2, 0));
                end else begin
                    res.push_back(filter_at(cur_row - 1, cur_col - 1, 0, 1, 2, 1));
                    if (last_row) res.push_back(filter_at(cur_row, cur_col - 1, 0, 1, 2, 0));
                end
            end
            if (row_end) begin
                res.push_back(filter_at(cur_row - 1, cur_col, 1, 2, 1, 1));
                if (last_row) res.push_back(filter_at(cur_row, cur_col, 1, 2, 1, 0));
            end
        end
        if (res.size() > 0) begin
            res[$].last = 1;
            res[$].done = last_row && row_end;
        end
        foreach (res[i]) expected_q.push_back(res[i]);
        if (row_end) begin
            cur_col = 0;
            cur_row = last_row ? 0 : cur_row + 1;
        end else begin
            cur_col = cur_col + 1;
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    bit tx_gaps = 1;

    task automatic send_pixel(logic [7:0] p);
        int g;
        g = tx_gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(p);
        n_items++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_e a, logic [47:0] v);
        cfg_we <= 1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        case (a)
            REG_KTOP:    k_top = v;
            REG_KMID:    k_mid = v;
            REG_KBOT:    k_bot = v;
            REG_FWIDTH:  fw_reg = v[10:0];
            REG_FHEIGHT: fh_reg = v[12:0];
            default: ;
        endcase
    endtask

    function automatic logic [47:0] rand_kernel();
        return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535))};
    endfunction

    task automatic set_frame(int w, int h, logic [47:0] kt, logic [47:0] km, logic [47:0] kb);
        write_reg(REG_KTOP, kt);
        write_reg(REG_KMID, km);
        write_reg(REG_KBOT, kb);
        write_reg(REG_FWIDTH, 48'(w));
        write_reg(REG_FHEIGHT, 48'(h));
        cfg_we <= 0;
    endtask

    task automatic send_frame(int w, int h, int mode);
        for (int i = 0; i < w * h; i++) begin
            case (mode)
                0: send_pixel(8'hFF);
                1: send_pixel(8'h00);
                default: send_pixel(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // smallest frame, extremes of pixels and coefficients
    task automatic test_extremes();
        set_frame(2, 2, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_frame(2, 2, 0);
        wait_idle();
        set_frame(2, 2, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_frame(2, 2, 0);
        send_frame(2, 2, 1);
        wait_idle();
        // out-of-range sizes clamp to 2
        set_frame(0, 1, 48'h0001_1000_FFFF, 48'h2000_F000_0100, 48'h0003_0002_0001);
        send_frame(2, 2, 2);
        wait_idle();
    endtask

    // odd shapes: 3x3 and narrow/tall, asymmetric kernels expose mirror errors
    task automatic test_shapes();
        set_frame(3, 3, 48'h0003_0002_0001, 48'h0006_0005_0004, 48'h0009_0008_0007);
        send_frame(3, 3, 2);
        wait_idle();
        set_frame(2, 5, rand_kernel(), rand_kernel(), rand_kernel());
        send_frame(2, 5, 2);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int w, h;
        while (n_items < 226) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(2, 9);
            h = $urandom_range(2, 6);
            if (n_items + w * h > 230) begin
                w = 2;
                h = 2;
            end
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_hold_off = $urandom_range(0, 3) == 0;
            set_frame(w, h, rand_kernel(), rand_kernel(), rand_kernel());
            send_frame(w, h, 2);
            wait_idle();
        end
        tx_gaps = 1;
        rx_hold_off = 0;
    endtask

    // wide frame, two rows
    task automatic test_wide_frame();
        set_frame(96, 2, rand_kernel(), rand_kernel(), rand_kernel());
        send_frame(96, 2, 2);
        wait_idle();
    endtask

    // tall narrow frame
    task automatic test_tall_frame();
        set_frame(2, 32, rand_kernel(), rand_kernel(), rand_kernel());
        send_frame(2, 32, 2);
        wait_idle();
    endtask

    // result checker
    always @(posedge aclk) begin
        conv_res_t got, exp_r;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.row = m_tdata[ROW_BITS-1:0];
            got.col = m_tdata[ROW_BITS +: OCOL_BITS];
            got.filt = m_tdata[ROW_BITS + OCOL_BITS +: FILT_BITS];
            got.last = m_tlast;
            got.done = m_tuser;
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected result row=%0d col=%0d", got.row, got.col);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (got.row !== exp_r.row) begin
                    $error("out_row exp %0d got %0d", exp_r.row, got.row); errors++;
                end
                if (got.col !== exp_r.col) begin
                    $error("out_col exp %0d got %0d", exp_r.col, got.col); errors++;
                end
                if (got.filt !== exp_r.filt) begin
                    $error("filtered exp %0d got %0d", $signed(exp_r.filt),
                           $signed(got.filt));
                    errors++;
                end
                if (got.last !== exp_r.last) begin
                    $error("run_last exp %0d got %0d", exp_r.last, got.last); errors++;
                end
                if (got.done !== exp_r.done) begin
                    $error("frame_done exp %0d got %0d", exp_r.done, got.done); errors++;
                end
            end
        end
    end

    // receiver back-pressure
    int stall_left = 0;
    always @(posedge aclk) begin
        if (rx_hold_off) begin
            m_tready <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else begin
            stall_left <= gap_len();
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("FAIL conv3x3_mirror_border_unit");
            $finish;
        end
    end

    initial begin
        k_top = 0; k_mid = 0; k_bot = 0; fw_reg = 2; fh_reg = 2;
        cur_row = 0; cur_col = 0;
        foreach (win[i, j]) win[i][j] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_extremes();
        test_shapes();
        test_random_frames();
        test_wide_frame();
        test_tall_frame();
        wait_idle();
        $display("Covered %0d pixels and %0d filtered results over frames 2x2 to 96 wide",
                 n_items, n_results);
        $display("and up to 32 rows, with random kernels and stalls on both sides.");
        if (errors == 0) begin
            $display("PASS conv3x3_mirror_border_unit");
        end else begin
            $display("FAIL conv3x3_mirror_border_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/cmb_pkg.sv
rtl/cmb_line_buf.sv
rtl/cmb_window.sv
rtl/cmb_mac.sv
rtl/conv3x3_mirror_border_unit.sv
bench/testbench.sv
